// ===== rtl/bsp_pkg.sv =====
package bsp_pkg;

   localparam int NODE_W    = 3;
   localparam int NUM_NODES = 8;
   localparam int MAX_NODES = 2 ** NODE_W;
   localparam int CNT_W     = NODE_W + 1;
   localparam int ADJ_W     = MAX_NODES * MAX_NODES;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   localparam node_type LAST_NODE = node_type'(NUM_NODES - 1);

   typedef struct packed {
      logic     go;
      node_type src;
      node_type dst;
   } query_type;

   typedef struct packed {
      logic    done;
      logic    found;
      cnt_type len;
   } result_type;

   function automatic logic node_ok(input node_type node);
      return (int'(node) < NUM_NODES);
   endfunction

endpackage

// ===== rtl/bsp_search.sv =====
module bsp_search (
   input  logic                          clock,
   input  logic                          reset,
   input  bsp_pkg::query_type            query,
   input  logic [bsp_pkg::ADJ_W-1:0]     adjacency,
   output bsp_pkg::result_type           result,
   output bsp_pkg::node_type             chain[bsp_pkg::MAX_NODES]
);
   import bsp_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DEQ  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_WALK = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic                 done_ff, done_in;
   logic                 found_ff, found_in;
   node_type             src_ff, src_in;
   node_type             dst_ff, dst_in;
   node_type             cur_ff, cur_in;
   node_type             n_ff, n_in;
   node_type             walk_ff, walk_in;
   cnt_type              head_ff, head_in;
   cnt_type              tail_ff, tail_in;
   cnt_type              len_ff, len_in;
   logic [MAX_NODES-1:0] visited_ff, visited_in;
   node_type             parent_ff[MAX_NODES];
   node_type             parent_in[MAX_NODES];
   node_type             fifo_ff[MAX_NODES];
   node_type             fifo_in[MAX_NODES];
   node_type             chain_ff[MAX_NODES];
   node_type             chain_in[MAX_NODES];
   logic                 edge_hit;

   // one adjacency bit per cycle: row of the current node, column n
   assign edge_hit = adjacency[{cur_ff, n_ff}] && !visited_ff[n_ff];

   always_comb begin
      state_in   = state_ff;
      done_in    = 1'b0;
      found_in   = found_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      cur_in     = cur_ff;
      n_in       = n_ff;
      walk_in    = walk_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      len_in     = len_ff;
      visited_in = visited_ff;
      parent_in  = parent_ff;
      fifo_in    = fifo_ff;
      chain_in   = chain_ff;
      case (state_ff)
         S_IDLE: begin
            if (query.go) begin
               src_in = query.src;
               dst_in = query.dst;
               if (!(node_ok(query.src) && node_ok(query.dst))) begin
                  done_in  = 1'b1;
                  found_in = 1'b0;
               end else if (query.src == query.dst) begin
                  chain_in[0] = query.src;
                  len_in      = cnt_type'(1);
                  found_in    = 1'b1;
                  done_in     = 1'b1;
               end else begin
                  fifo_in[0]             = query.src;
                  head_in                = '0;
                  tail_in                = cnt_type'(1);
                  visited_in             = '0;
                  visited_in[query.src]  = 1'b1;
                  state_in               = S_DEQ;
               end
            end
         end
         S_DEQ: begin
            if (head_ff == tail_ff) begin
               done_in  = 1'b1;
               found_in = 1'b0;
               state_in = S_IDLE;
            end else begin
               cur_in   = fifo_ff[head_ff[NODE_W-1:0]];
               head_in  = head_ff + cnt_type'(1);
               n_in     = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (edge_hit) begin
               visited_in[n_ff] = 1'b1;
               parent_in[n_ff]  = cur_ff;
               if (tail_ff < cnt_type'(MAX_NODES)) begin
                  fifo_in[tail_ff[NODE_W-1:0]] = n_ff;
                  tail_in                      = tail_ff + cnt_type'(1);
               end
            end
            if (edge_hit && n_ff == dst_ff) begin
               walk_in  = dst_ff;
               len_in   = '0;
               state_in = S_WALK;
            end else if (n_ff == LAST_NODE) begin
               state_in = S_DEQ;
            end else begin
               n_in = n_ff + node_type'(1);
            end
         end
         S_WALK: begin
            // chain is built goal first, the start node lands last
            chain_in[len_ff[NODE_W-1:0]] = walk_ff;
            len_in                       = len_ff + cnt_type'(1);
            if (walk_ff == src_ff) begin
               done_in  = 1'b1;
               found_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               walk_in = parent_ff[walk_ff];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      found_ff   <= found_in;
      src_ff     <= src_in;
      dst_ff     <= dst_in;
      cur_ff     <= cur_in;
      n_ff       <= n_in;
      walk_ff    <= walk_in;
      head_ff    <= head_in;
      tail_ff    <= tail_in;
      len_ff     <= len_in;
      visited_ff <= visited_in;
      parent_ff  <= parent_in;
      fifo_ff    <= fifo_in;
      chain_ff   <= chain_in;
   end

   assign result.done  = done_ff;
   assign result.found = found_ff;
   assign result.len   = len_ff;
   assign chain        = chain_ff;

   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEQ || state_ff == S_SCAN) |-> head_ff <= tail_ff)
      else $error("queue head passed tail");

   a_src_visited: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> visited_ff[src_ff])
      else $error("start node not marked visited during scan");

   a_walk_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> len_ff < cnt_type'(MAX_NODES))
      else $error("path walk longer than node count");

endmodule

// ===== rtl/bfs_shortest_path_finder_core.sv =====
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_from_node, req_to_node
// rsp       out        rsp_valid / rsp_ready  rsp_path_node, rsp_last, rsp_status
// csr       in         csr_wr_en              csr_wr_data (adjacency matrix)
//
// from acceptance: per dequeued node, a dequeue step then a scan of its adjacency row (one adjacency bit per cycle),
// one more dequeue step on no path, one walk step per path node, then the result is emitted
// at one transfer per cycle while rsp_ready is held high.
// reset clears the adjacency matrix and all control state.
// req_ready is low from query acceptance until the last result is loaded; a stalled
// rsp holds the emission without losing state.
module bfs_shortest_path_finder_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bsp_pkg::node_type             req_from_node,
   input  bsp_pkg::node_type             req_to_node,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bsp_pkg::node_type             rsp_path_node,
   output logic                          rsp_last,
   output logic                          rsp_status,
   input  logic                          csr_wr_en,
   input  logic [bsp_pkg::ADJ_W-1:0]     csr_wr_data
);
   import bsp_pkg::*;

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_BUSY = 2'd1;
   localparam logic [1:0] T_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [ADJ_W-1:0] adj_ff;
   logic             found_ff, found_in;
   node_type         idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   node_type         node_ff, node_in;
   logic             last_ff, last_in;
   logic             status_ff, status_in;
   query_type        query;
   result_type       result;
   node_type         chain[MAX_NODES];

   assign req_ready    = (state_ff == T_IDLE);
   assign query.go     = req_valid && req_ready;
   assign query.src    = req_from_node;
   assign query.dst    = req_to_node;

   bsp_search u_search (
      .clock     (clock),
      .reset     (reset),
      .query     (query),
      .adjacency (adj_ff),
      .result    (result),
      .chain     (chain)
   );

   always_comb begin
      state_in     = state_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      node_in      = node_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      case (state_ff)
         T_IDLE: begin
            if (query.go) begin
               state_in = T_BUSY;
            end
         end
         T_BUSY: begin
            if (result.done) begin
               found_in = result.found;
               idx_in   = node_type'(result.len - cnt_type'(1));
               state_in = T_EMIT;
            end
         end
         T_EMIT: begin
            // load the output register once it is free, start node first
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  node_in   = chain[idx_ff];
                  last_in   = (idx_ff == '0);
                  status_in = 1'b0;
                  if (idx_ff == '0) begin
                     state_in = T_IDLE;
                  end else begin
                     idx_in = idx_ff - node_type'(1);
                  end
               end else begin
                  node_in   = '0;
                  last_in   = 1'b1;
                  status_in = 1'b1;
                  state_in  = T_IDLE;
               end
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
         adj_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            adj_ff <= csr_wr_data;
         end
      end
      found_ff  <= found_in;
      idx_ff    <= idx_in;
      node_ff   <= node_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_path_node = node_ff;
   assign rsp_last      = last_ff;
   assign rsp_status    = status_ff;

   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      result.done |-> state_ff == T_BUSY)
      else $error("search finished while no query was pending");

   a_accept_to_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == T_BUSY)
      else $error("accepted query did not start a search");

   a_fail_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_last && rsp_path_node == '0))
      else $error("no-path result not a lone final transfer");

endmodule

// ===== test/bfs_shortest_path_finder_core_tb.sv =====
`timescale 1ns / 100ps

module bfs_shortest_path_finder_core_tb;
   import bsp_pkg::*;

   localparam int ROW_STRIDE   = 8;
   localparam int SETTLE_WAIT  = 100;
   localparam int LONG_HOLD    = 400;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int MAX_REPORTS  = 10;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_QUERIES = 60;

   typedef struct {
      node_type src;
      node_type dst;
   } pending_query_type;

   typedef struct {
      node_type node;
      logic     last;
      logic     status;
   } path_step_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   node_type         req_from_node = '0;
   node_type         req_to_node = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   node_type         rsp_path_node;
   logic             rsp_last;
   logic             rsp_status;
   logic             csr_wr_en = 1'b0;
   logic [ADJ_W-1:0] csr_wr_data = '0;

   logic [ADJ_W-1:0]  adjacency_model = '0;
   pending_query_type pending_queries[$];
   path_step_type     expected_path[$];
   pending_query_type next_query;
   path_step_type     want;
   logic              send_on = 1'b0;
   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;
   logic              stall_request = 1'b0;
   int                rsp_hold_left = 0;
   int                fail_count = 0;
   int                result_count = 0;

   bfs_shortest_path_finder_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_from_node (req_from_node),
      .req_to_node   (req_to_node),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_path_node (rsp_path_node),
      .rsp_last      (rsp_last),
      .rsp_status    (rsp_status),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("mismatch: %s", what);
      end
   endtask

   // breadth-first search from src, successors in ascending order, first finder is parent
   function automatic void predict_path(input node_type src, input node_type dst);
      node_type             parent[MAX_NODES];
      node_type             frontier[MAX_NODES];
      node_type             route[MAX_NODES];
      logic [MAX_NODES-1:0] seen;
      node_type             cur;
      path_step_type        step;
      logic                 found;
      int                   head;
      int                   tail;
      int                   len;
      head  = 0;
      tail  = 0;
      len   = 0;
      seen  = '0;
      found = 1'b0;
      if (int'(src) >= NUM_NODES || int'(dst) >= NUM_NODES) begin
         step.node   = '0;
         step.last   = 1'b1;
         step.status = 1'b1;
         expected_path = {expected_path, step};
         return;
      end
      if (src == dst) begin
         step.node   = src;
         step.last   = 1'b1;
         step.status = 1'b0;
         expected_path = {expected_path, step};
         return;
      end
      for (int k = 0; k < MAX_NODES; k++) begin
         parent[k] = node_type'(k);
      end
      frontier[tail] = src;
      tail++;
      seen[src] = 1'b1;
      while (head < tail && !found) begin
         cur = frontier[head];
         head++;
         for (int n = 0; n < NUM_NODES && n < MAX_NODES && !found; n++) begin
            if (adjacency_model[int'(cur) * ROW_STRIDE + n] && !seen[n]) begin
               seen[n]   = 1'b1;
               parent[n] = cur;
               if (tail < MAX_NODES) begin
                  frontier[tail] = node_type'(n);
                  tail++;
               end
               if (node_type'(n) == dst) begin
                  found = 1'b1;
               end
            end
         end
      end
      if (!found) begin
         step.node   = '0;
         step.last   = 1'b1;
         step.status = 1'b1;
         expected_path = {expected_path, step};
         return;
      end
      cur = dst;
      while (cur != src && len < MAX_NODES) begin
         route[len] = cur;
         len++;
         cur = parent[cur];
      end
      if (len < MAX_NODES) begin
         route[len] = src;
         len++;
      end
      for (int k = 0; k < len; k++) begin
         step.node   = route[len - 1 - k];
         step.last   = (k + 1 == len);
         step.status = 1'b0;
         expected_path = {expected_path, step};
      end
   endfunction

   // driver: payload held until the transfer, prediction taken at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_path(req_from_node, req_to_node);
         end
         if (!req_valid || req_ready) begin
            if (send_on && pending_queries.size() != 0
                && $urandom_range(99) >= send_idle_pct) begin
               next_query = pending_queries.pop_front();
               req_from_node <= next_query.src;
               req_to_node   <= next_query.dst;
               req_valid     <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold_left <= 0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (stall_request) begin
         rsp_hold_left <= LONG_HOLD;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_path.size() == 0) begin
               note_failure($sformatf("result with nothing expected: node %0d last %0b status %0b",
                                      rsp_path_node, rsp_last, rsp_status));
            end else begin
               want = expected_path.pop_front();
               if (rsp_path_node !== want.node || rsp_last !== want.last
                   || rsp_status !== want.status) begin
                  note_failure($sformatf(
                     "result %0d: expected node %0d last %0b status %0b, got %0d %0b %0b",
                     result_count, want.node, want.last, want.status,
                     rsp_path_node, rsp_last, rsp_status));
               end
            end
            result_count++;
         end
         rsp_ready <= (rsp_hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   task automatic add_query(input int from_node, input int to_node);
      pending_query_type q;
      q.src = node_type'(from_node);
      q.dst = node_type'(to_node);
      pending_queries = {pending_queries, q};
   endtask

   task automatic write_adjacency(input logic [ADJ_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      adjacency_model = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // send what is pending, optionally with a long receiver hold-off, then drain
   task automatic run_queries(input int idle_pct, input int stall_pct, input logic long_hold);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      send_on = 1'b1;
      if (long_hold) begin
         stall_request = 1'b1;
         do @(negedge clock); while (rsp_hold_left == 0);
         stall_request = 1'b0;
      end
      do @(negedge clock);
      while (pending_queries.size() != 0 || req_valid || expected_path.size() != 0);
      send_on = 1'b0;
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   function automatic logic [ADJ_W-1:0] random_graph(input int density_pct, input logic chained);
      logic [ADJ_W-1:0] graph;
      int               order[MAX_NODES];
      int               pick;
      int               swap;
      graph = '0;
      for (int b = 0; b < ADJ_W; b++) begin
         graph[b] = ($urandom_range(99) < density_pct);
      end
      if (chained) begin
         // random permutation threaded into one long path
         for (int k = 0; k < MAX_NODES; k++) begin
            order[k] = k;
         end
         for (int k = MAX_NODES - 1; k > 0; k--) begin
            pick = $urandom_range(k);
            swap = order[k];
            order[k] = order[pick];
            order[pick] = swap;
         end
         for (int k = 0; k < MAX_NODES - 1; k++) begin
            graph[order[k] * ROW_STRIDE + order[k + 1]] = 1'b1;
         end
      end
      return graph;
   endfunction

   initial begin
      logic [ADJ_W-1:0] graph;
      int               density[RANDOM_PHASES];
      density = '{20, 35, 10, 60, 5, 25, 45, 15};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty graph straight out of reset
      add_query(0, 0);
      add_query(7, 7);
      add_query(0, 7);
      run_queries(0, 0, 1'b0);

      // single chain 0..7, longest possible path
      graph = '0;
      for (int k = 0; k < MAX_NODES - 1; k++) begin
         graph[k * ROW_STRIDE + k + 1] = 1'b1;
      end
      write_adjacency(graph);
      add_query(0, 7);
      add_query(7, 0);
      add_query(2, 5);
      add_query(6, 6);
      run_queries(31, 31, 1'b0);

      write_adjacency('1);
      add_query(0, 7);
      add_query(7, 0);
      add_query(5, 1);
      add_query(3, 3);
      run_queries(0, 0, 1'b0);

      // diamond with self loops: ties go to the lower index
      graph = '0;
      graph[0 * ROW_STRIDE + 0] = 1'b1;
      graph[0 * ROW_STRIDE + 1] = 1'b1;
      graph[0 * ROW_STRIDE + 2] = 1'b1;
      graph[1 * ROW_STRIDE + 3] = 1'b1;
      graph[2 * ROW_STRIDE + 3] = 1'b1;
      graph[3 * ROW_STRIDE + 3] = 1'b1;
      graph[3 * ROW_STRIDE + 4] = 1'b1;
      graph[4 * ROW_STRIDE + 1] = 1'b1;
      write_adjacency(graph);
      add_query(0, 3);
      add_query(0, 4);
      add_query(4, 3);
      add_query(2, 0);
      add_query(3, 4);
      run_queries(46, 46, 1'b0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_adjacency(random_graph(density[p], p % 3 != 1));
         for (int i = 0; i < PHASE_QUERIES; i++) begin
            add_query($urandom_range(7), $urandom_range(7));
         end
         case (p % 4)
            0: begin
               run_queries(0, 0, p == 4);
            end
            1: begin
               run_queries(46, 0, 1'b0);
            end
            2: begin
               run_queries(0, 46, 1'b0);
            end
            default: begin
               run_queries(31, 31, 1'b0);
            end
         endcase
      end

      if (expected_path.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", expected_path.size()));
      end
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
